// File: rtl/core/bounded_deque_with_dump_assert.svh
// Assertion macros shared by the deque RTL.
// Needs clk and rst in the scope where a macro is used.
`ifndef BOUNDED_DEQUE_WITH_DUMP_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_DUMP_ASSERT_SVH

// Holds at every edge outside reset.
`define BDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bdq_pkg.sv
// Package for the bounded deque: request codes, status codes, field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 7;

  // Request codes
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DUMP_FWD   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DUMP_REV   = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/bounded_deque_with_dump.sv
// Bounded double-ended queue with front/back push, pop and dump requests.
// Depends on bdq_pkg and bounded_deque_with_dump_assert.svh.
//
//   channel  | dir | tdata                       | tuser       | tlast
//   ---------+-----+-----------------------------+-------------+---------------
//   s_*      | in  | [31:0] value                | [2:0] func  | -
//   m_*      | out | [31:0] item, [38:32] count, | [1:0] status| last of request
//            |     | [39] empty_res, [47:40] 0   |             |
//
// Push, pop and unused codes give one result each; one item per clock
//   while the result register drains.
// A dump of n words gives n result items at one per clock while m_tready is
//   high; the input is held off until the last word leaves the read register.
// Reset: rst clears front index, count, dump state and output valid. The store
//   itself is not cleared; only occupied slots are ever read.
// Stalls: m_tready low freezes the result register; during a dump the fetched
//   word waits in the store's read register and no new read is issued.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_deque_with_dump_assert.svh"

module bounded_deque_with_dump #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] value
  input  wire logic [2:0]  s_tuser,   // [2:0] func
  // result
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [31:0] item, [38:32] count, [39] empty_res
  output logic [1:0]       m_tuser,   // [1:0] status
  output logic             m_tlast
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // slot index width
  localparam int CW = $clog2(DEPTH + 1);                // occupancy width

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  bdq_pkg::state_t state, state_next;
  logic [AW-1:0]   front, front_next;
  logic [CW-1:0]   occ, occ_next;

  // dump sequencer
  logic [CW-1:0]   dump_left, dump_left_next;   // reads still to issue
  logic [AW-1:0]   dump_off, dump_off_next;     // offset of next read
  logic            dump_rev, dump_rev_next;
  logic            rd_valid, rd_valid_next;     // rd_data holds an unsent word
  logic            rd_last;                     // that word is the final one

  // word store
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [AW-1:0]         wr_addr;
  logic                  wr_en;
  logic [AW-1:0]         rd_addr;
  logic                  rd_en;

  // result register
  logic                          out_valid;
  logic [bdq_pkg::STATUS_W-1:0]  out_status;
  logic [bdq_pkg::WORD_W-1:0]    out_item;
  logic                          out_last;
  logic [bdq_pkg::COUNT_W-1:0]   out_count;
  logic                          out_empty;

  logic [bdq_pkg::WORD_W-1:0]    item_ext;
  logic                          out_free;
  logic                          in_acc;
  logic                          dump_load;
  logic                          ctl_load;
  logic [bdq_pkg::STATUS_W-1:0]  ctl_status;
  logic                          full, is_empty;
  logic [AW:0]                   back_sum, rd_sum;

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == bdq_pkg::S_IDLE) && out_free;
  assign in_acc   = s_tvalid && s_tready;

  assign full     = (occ == CW'(DEPTH));
  assign is_empty = (occ == '0);

  // Width of the stored word vs the 32-bit port
  generate
    if (DATA_WIDTH < bdq_pkg::WORD_W) begin : g_narrow
      assign wr_data  = s_tdata[DATA_WIDTH-1:0];
      assign item_ext = {{(bdq_pkg::WORD_W-DATA_WIDTH){rd_data[DATA_WIDTH-1]}}, rd_data};
    end else if (DATA_WIDTH == bdq_pkg::WORD_W) begin : g_same
      assign wr_data  = s_tdata;
      assign item_ext = rd_data;
    end else begin : g_wide
      assign wr_data  = {{(DATA_WIDTH-bdq_pkg::WORD_W){1'b0}}, s_tdata};
      assign item_ext = rd_data[bdq_pkg::WORD_W-1:0];
    end
  endgenerate

  // slot = (front + offset) mod DEPTH, offset < DEPTH
  assign back_sum = {1'b0, front} + (AW+1)'(occ);
  assign rd_sum   = {1'b0, front} + {1'b0, dump_off};

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next     = state;
    front_next     = front;
    occ_next       = occ;
    dump_left_next = dump_left;
    dump_off_next  = dump_off;
    dump_rev_next  = dump_rev;
    rd_valid_next  = rd_valid;
    wr_en          = 1'b0;
    wr_addr        = front;
    rd_en          = 1'b0;
    rd_addr        = (rd_sum >= (AW+1)'(DEPTH)) ? AW'(rd_sum - (AW+1)'(DEPTH))
                                                 : AW'(rd_sum);
    ctl_load       = 1'b0;
    ctl_status     = bdq_pkg::ST_OK;
    dump_load      = 1'b0;

    case (state)
      bdq_pkg::S_IDLE: begin
        if (in_acc) begin
          ctl_load = 1'b1;
          case (s_tuser)
            bdq_pkg::FN_PUSH_FRONT, bdq_pkg::FN_PUSH_BACK: begin
              if (full) begin
                ctl_status = bdq_pkg::ST_FULL;
              end else begin
                wr_en    = 1'b1;
                occ_next = occ + 1'b1;
                if (s_tuser == bdq_pkg::FN_PUSH_FRONT) begin
                  front_next = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;
                  wr_addr    = front_next;
                end else begin
                  wr_addr = (back_sum >= (AW+1)'(DEPTH)) ?
                            AW'(back_sum - (AW+1)'(DEPTH)) : AW'(back_sum);
                end
              end
            end
            bdq_pkg::FN_POP_FRONT, bdq_pkg::FN_POP_BACK: begin
              if (is_empty) begin
                ctl_status = bdq_pkg::ST_EMPTY;
              end else begin
                occ_next = occ - 1'b1;
                if (s_tuser == bdq_pkg::FN_POP_FRONT) begin
                  front_next = (front == AW'(DEPTH - 1)) ? '0 : front + 1'b1;
                end
              end
            end
            bdq_pkg::FN_DUMP_FWD, bdq_pkg::FN_DUMP_REV: begin
              if (is_empty) begin
                ctl_status = bdq_pkg::ST_EMPTY;
              end else begin
                // results come from the dump sequencer instead
                ctl_load       = 1'b0;
                state_next     = bdq_pkg::S_DUMP;
                dump_left_next = occ;
                dump_rev_next  = (s_tuser == bdq_pkg::FN_DUMP_REV);
                dump_off_next  = (s_tuser == bdq_pkg::FN_DUMP_REV) ? AW'(occ - 1'b1)
                                                                   : '0;
                rd_valid_next  = 1'b0;
              end
            end
            default: begin
              // unused codes: plain ok result, nothing changes
            end
          endcase
        end
      end

      bdq_pkg::S_DUMP: begin
        dump_load = rd_valid && out_free;
        if (dump_load) begin
          rd_valid_next = 1'b0;
          if (rd_last) begin
            state_next = bdq_pkg::S_IDLE;
          end
        end
        // fetch next word when the read register is empty or being drained
        if ((dump_left != '0) && (!rd_valid || dump_load)) begin
          rd_en          = 1'b1;
          rd_valid_next  = 1'b1;
          dump_left_next = dump_left - 1'b1;
          dump_off_next  = dump_rev ? dump_off - 1'b1 : dump_off + 1'b1;
        end
      end

      default: begin
        state_next = bdq_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bdq_pkg::S_IDLE;
      front     <= '0;
      occ       <= '0;
      dump_left <= '0;
      dump_rev  <= 1'b0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      front     <= front_next;
      occ       <= occ_next;
      dump_left <= dump_left_next;
      dump_rev  <= dump_rev_next;
      rd_valid  <= rd_valid_next;
      if (ctl_load || dump_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dump_off <= dump_off_next;
    if (rd_en) begin
      rd_last <= (dump_left == CW'(1));
    end
    if (ctl_load) begin
      out_status <= ctl_status;
      out_item   <= '0;
      out_last   <= 1'b1;
      out_count  <= bdq_pkg::COUNT_W'(occ_next);
      out_empty  <= (occ_next == '0);
    end else if (dump_load) begin
      out_status <= bdq_pkg::ST_OK;
      out_item   <= item_ext;
      out_last   <= rd_last;
      out_count  <= bdq_pkg::COUNT_W'(occ);
      out_empty  <= 1'b0;
    end
  end

  // word store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;
  assign m_tdata  = {8'd0, out_empty, out_count, out_item};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BDQ_ASSERT(a_occ_bound, occ <= CW'(DEPTH), "occupancy above depth")
  `BDQ_ASSERT_NEXT(a_occ_hold, !in_acc, $stable(occ), "occupancy moved without a request")
  `BDQ_ASSERT(a_rd_in_dump, !rd_valid || (state == bdq_pkg::S_DUMP), "fetched word outside dump")
  `BDQ_ASSERT(a_no_write_dump, !(wr_en && (state == bdq_pkg::S_DUMP)), "store written during dump")

endmodule

`default_nettype wire
